### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the segment state checker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check on every rising clock edge outside reset.
`define SSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check on every rising clock edge, reset included.
`define SSC_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SSC_ASSERT(lbl, prop, msg)
`define SSC_ASSERT_NR(lbl, prop, msg)
`endif

`endif

### src/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types and codes of the segment state checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

  localparam int IN_W    = 80;
  localparam int OUT_W   = 40;
  localparam int ID_W    = 10;
  localparam int BYTE_W  = 31;
  localparam int OP_W    = 3;
  localparam int SEG_W   = 2;
  localparam int RC_W    = 2;
  localparam int LOG_W   = 5;
  localparam int NSEG_W  = 11;
  localparam int ENTRY_W = SEG_W + BYTE_W;
  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;

  // Command opcodes
  localparam logic [OP_W-1:0] OP_OPEN    = 3'd0;
  localparam logic [OP_W-1:0] OP_CLOSE   = 3'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ    = 3'd4;
  localparam logic [OP_W-1:0] OP_RECOVER = 3'd5;

  // Segment states
  localparam logic [SEG_W-1:0] SEG_EMPTY  = 2'd0;
  localparam logic [SEG_W-1:0] SEG_OPEN   = 2'd1;
  localparam logic [SEG_W-1:0] SEG_CLOSED = 2'd2;

  // Result status codes
  localparam logic [RC_W-1:0] RC_OK    = 2'd0;
  localparam logic [RC_W-1:0] RC_INVAL = 2'd1;
  localparam logic [RC_W-1:0] RC_NOSPC = 2'd2;
  localparam logic [RC_W-1:0] RC_NOENT = 2'd3;

  // Register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_BLK_LOG2 = 2'd0;
  localparam logic [1:0] REG_SEG_SIZE = 2'd1;
  localparam logic [1:0] REG_NUM_SEG  = 2'd2;

  localparam logic [LOG_W-1:0]  BLK_LOG2_RST = 5'd12;
  localparam logic [BYTE_W-1:0] SEG_SIZE_RST = 31'd67108864;
  localparam logic [NSEG_W-1:0] NUM_SEG_RST  = 11'd1024;

  typedef struct packed {
    logic [LOG_W-1:0]  blk_log2;
    logic [BYTE_W-1:0] seg_size;
    logic [NSEG_W-1:0] num_seg;
  } ssc_cfg_t;

  typedef struct packed {
    logic load_item;  // capture the accepted item
    logic rd_item;    // read the table entry of the accepted item
    logic cnt_clr;    // restart the walk counter
    logic sweep_rd;   // read the entry at the walk counter, advance
    logic clear_wr;   // zero the entry at the walk counter, advance
    logic commit;     // write back the command and load the result
  } ssc_cmd_t;

  typedef struct packed {
    logic is_recover;
    logic cnt_last;
    logic sweep_done;
    logic pend;
    logic out_free;
  } ssc_sts_t;

endpackage

`default_nettype wire

### src/segment_state_checker_core.sv
// ----------------------------------------------------------------------------
// segment_state_checker_core
// Segment state and write pointer checker of a zoned store.
// ----------------------------------------------------------------------------
// Each command item yields exactly one result item. A plain command reads the
// segment's table entry, then checks it, writes it back and loads the result
// register; it stalls only while the previous result still waits in that
// register. Recover walks the first active_count table entries one entry a
// cycle, where active_count is min(num_segments, MAX_SEGMENTS). After reset
// all MAX_SEGMENTS entries of the table (1024 by default) are cleared one
// entry a cycle, a pass during which no item is taken; configuration
// writes are accepted at all times but must be issued only while the block
// is idle.
`default_nettype none

module segment_state_checker_core #(
  parameter int MAX_SEGMENTS = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // tdata: opcode[2:0], segment_id[12:3], offset[43:13], length[74:44], zero
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [ssc_pkg::IN_W-1:0]   in_tdata,
  // tdata: status[1:0], unwritten byte count[32:2], zero
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic      [ssc_pkg::OUT_W-1:0]  out_tdata,
  // APB: block size log2 at 0x0, segment size at 0x4, segment count at 0x8
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [ssc_pkg::APB_AW-1:0] cfg_paddr,
  input  wire logic [ssc_pkg::APB_DW-1:0] cfg_pwdata,
  output logic      [ssc_pkg::APB_DW-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import ssc_pkg::*;

  ssc_cfg_t cfg;
  ssc_cmd_t cmd;
  ssc_sts_t sts;

  // configuration registers
  ssc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  // sequencer: clear pass, command execute, recover walk
  ssc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // segment table, checks and result register
  ssc_dpath #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_i      (cfg),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

### src/ssc_regs.sv
// ----------------------------------------------------------------------------
// ssc_regs
// APB configuration registers: block size, segment size, segment count.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [ssc_pkg::APB_AW-1:0] cfg_paddr,
  input  wire logic [ssc_pkg::APB_DW-1:0] cfg_pwdata,
  output logic      [ssc_pkg::APB_DW-1:0] cfg_prdata,
  output logic                            cfg_pready,
  output ssc_pkg::ssc_cfg_t               cfg_o
);
  import ssc_pkg::*;

  logic [LOG_W-1:0]  blk_log2_r;
  logic [BYTE_W-1:0] seg_size_r;
  logic [NSEG_W-1:0] num_seg_r;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_log2_r <= BLK_LOG2_RST;
      seg_size_r <= SEG_SIZE_RST;
      num_seg_r  <= NUM_SEG_RST;
    end else if (wr_en) begin
      if (reg_idx == REG_BLK_LOG2) blk_log2_r <= cfg_pwdata[LOG_W-1:0];
      if (reg_idx == REG_SEG_SIZE) seg_size_r <= cfg_pwdata[BYTE_W-1:0];
      if (reg_idx == REG_NUM_SEG)  num_seg_r  <= cfg_pwdata[NSEG_W-1:0];
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BLK_LOG2: cfg_prdata = APB_DW'(blk_log2_r);
      REG_SEG_SIZE: cfg_prdata = APB_DW'(seg_size_r);
      REG_NUM_SEG:  cfg_prdata = APB_DW'(num_seg_r);
      default:      cfg_prdata = '0;
    endcase
  end

  assign cfg_o.blk_log2 = blk_log2_r;
  assign cfg_o.seg_size = seg_size_r;
  assign cfg_o.num_seg  = num_seg_r;

endmodule

`default_nettype wire

### src/ssc_ctrl.sv
// ----------------------------------------------------------------------------
// ssc_ctrl
// Command sequencer: table clear, command execute and recover walk.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  ssc_pkg::ssc_sts_t  sts_i,
  output ssc_pkg::ssc_cmd_t  cmd_o
);
  import ssc_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.cnt_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load_item = 1'b1;
          cmd_o.rd_item   = 1'b1;
          if (sts_i.is_recover) begin
            cmd_o.cnt_clr = 1'b1;
            state_nxt     = ST_SWEEP;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end
      ST_SWEEP: begin
        // drain the last write-back before reporting
        if (!sts_i.sweep_done) begin
          cmd_o.sweep_rd = 1'b1;
        end else if (!sts_i.pend) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### src/ssc_dpath.sv
// ----------------------------------------------------------------------------
// ssc_dpath
// Segment table, item registers, checks and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_dpath #(
  parameter int MAX_SEGMENTS = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  ssc_pkg::ssc_cmd_t              cmd_i,
  output ssc_pkg::ssc_sts_t              sts_o,
  input  ssc_pkg::ssc_cfg_t              cfg_i,
  input  wire logic [ssc_pkg::IN_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic      [ssc_pkg::OUT_W-1:0] out_tdata
);
  import ssc_pkg::*;
  `include "assert_macros.svh"

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  // table entry: {state, write pointer}
  logic [ENTRY_W-1:0] seg_mem_r [0:MAX_SEGMENTS-1];
  logic [ENTRY_W-1:0] rd_q_r;

  logic [OP_W-1:0]    op_r;
  logic [ID_W-1:0]    id_r;
  logic [BYTE_W-1:0]  off_r;
  logic [BYTE_W-1:0]  len_r;

  logic [CW-1:0]      cnt_r;
  logic [CW-1:0]      cnt_nxt;
  logic               pend_r;
  logic [AW-1:0]      pend_addr_r;

  logic               out_tvalid_r;
  logic               out_tvalid_nxt;
  logic [RC_W-1:0]    out_sts_r;
  logic [BYTE_W-1:0]  out_unused_r;

  logic [CW-1:0]      active_cnt;
  logic               in_range;
  logic [31:0]        blk_mask;
  logic               off_al;
  logic               len_al;
  logic [BYTE_W:0]    end_sum;
  logic               over;
  logic [SEG_W-1:0]   cur_st;
  logic [BYTE_W-1:0]  cur_ptr;

  logic [RC_W-1:0]    res_sts;
  logic [BYTE_W-1:0]  res_unused;
  logic               res_wr;
  logic [ENTRY_W-1:0] res_entry;

  logic               wb_en;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [ENTRY_W-1:0] mem_wd;
  logic               mem_re;
  logic [AW-1:0]      mem_ra;
  logic [2:0]         wr_src;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd_i.load_item) begin
      op_r  <= in_tdata[2:0];
      id_r  <= in_tdata[12:3];
      off_r <= in_tdata[43:13];
      len_r <= in_tdata[74:44];
    end
  end

  assign active_cnt = (32'(cfg_i.num_seg) < 32'(MAX_SEGMENTS)) ?
                      CW'(cfg_i.num_seg) : CW'(MAX_SEGMENTS);

  // walk counter for the clear pass and the recover sweep
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd_i.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd_i.sweep_rd || cmd_i.clear_wr) begin
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      pend_r <= cmd_i.sweep_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.sweep_rd) pend_addr_r <= cnt_r[AW-1:0];
  end

  assign cur_st  = rd_q_r[ENTRY_W-1:BYTE_W];
  assign cur_ptr = rd_q_r[BYTE_W-1:0];

  // checks
  assign in_range = 32'(id_r) < 32'(active_cnt);
  assign blk_mask = (32'd1 << cfg_i.blk_log2) - 32'd1;
  assign off_al   = (off_r & blk_mask[BYTE_W-1:0]) == '0;
  assign len_al   = (len_r & blk_mask[BYTE_W-1:0]) == '0;
  assign end_sum  = {1'b0, off_r} + {1'b0, len_r};
  assign over     = end_sum > {1'b0, cfg_i.seg_size};

  always_comb begin
    res_sts    = RC_INVAL;
    res_unused = '0;
    res_wr     = 1'b0;
    res_entry  = rd_q_r;
    case (op_r)
      OP_OPEN: begin
        if (in_range && cur_st == SEG_EMPTY) begin
          res_wr    = 1'b1;
          res_entry = {SEG_OPEN, {BYTE_W{1'b0}}};
          res_sts   = RC_OK;
        end
      end
      OP_CLOSE: begin
        if (in_range) begin
          res_wr     = 1'b1;
          res_entry  = {SEG_CLOSED, cur_ptr};
          res_sts    = RC_OK;
          res_unused = (cfg_i.seg_size > cur_ptr) ? (cfg_i.seg_size - cur_ptr) : '0;
        end
      end
      OP_RELEASE: begin
        if (in_range && cur_st == SEG_CLOSED) begin
          res_wr    = 1'b1;
          res_entry = {SEG_EMPTY, cur_ptr};
          res_sts   = RC_OK;
        end
      end
      OP_WRITE: begin
        if (!in_range || cur_st != SEG_OPEN) begin
          res_sts = RC_INVAL;
        end else if (off_r < cur_ptr || !off_al || !len_al) begin
          res_sts = RC_INVAL;
        end else if (over) begin
          res_sts = RC_NOSPC;
        end else begin
          res_wr    = 1'b1;
          res_entry = {SEG_OPEN, end_sum[BYTE_W-1:0]};
          res_sts   = RC_OK;
        end
      end
      OP_READ: begin
        if (!off_al || !len_al || !in_range || over) begin
          res_sts = RC_INVAL;
        end else if (cur_st == SEG_EMPTY) begin
          res_sts = RC_NOENT;
        end else begin
          res_sts = RC_OK;
        end
      end
      OP_RECOVER: res_sts = RC_OK;
      default:    res_sts = RC_INVAL;
    endcase
  end

  // table ports
  assign wb_en  = pend_r && (cur_st == SEG_OPEN);
  assign wr_src = {cmd_i.clear_wr, wb_en, cmd_i.commit && res_wr};

  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    if (cmd_i.clear_wr) begin
      mem_we = 1'b1;
      mem_wa = cnt_r[AW-1:0];
    end else if (wb_en) begin
      mem_we = 1'b1;
      mem_wa = pend_addr_r;
      mem_wd = {SEG_CLOSED, cur_ptr};
    end else if (cmd_i.commit && res_wr) begin
      mem_we = 1'b1;
      mem_wa = AW'(id_r);
      mem_wd = res_entry;
    end
  end

  assign mem_re = cmd_i.rd_item || cmd_i.sweep_rd;
  assign mem_ra = cmd_i.rd_item ? AW'(in_tdata[12:3]) : cnt_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) seg_mem_r[mem_wa] <= mem_wd;
    if (mem_re) rd_q_r <= seg_mem_r[mem_ra];
  end

  // result register
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (cmd_i.commit) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.commit) begin
      out_sts_r    <= res_sts;
      out_unused_r <= res_unused;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_W - RC_W - BYTE_W){1'b0}}, out_unused_r, out_sts_r};

  assign sts_o.is_recover = in_tdata[2:0] == OP_RECOVER;
  assign sts_o.cnt_last   = cnt_r == CW'(MAX_SEGMENTS - 1);
  assign sts_o.sweep_done = cnt_r >= active_cnt;
  assign sts_o.pend       = pend_r;
  assign sts_o.out_free   = !out_tvalid_r || out_tready;

  `SSC_ASSERT(a_one_writer, $onehot0(wr_src), "two sources write the segment table at once")
  `SSC_ASSERT(a_sweep_no_clash, (pend_r && cmd_i.sweep_rd) |-> (pend_addr_r != cnt_r[AW-1:0]), "sweep reads the entry it writes back")
  `SSC_ASSERT(a_out_from_commit, $rose(out_tvalid_r) |-> $past(cmd_i.commit), "result shown without a commit")
  `SSC_ASSERT_NR(a_rst_quiet, !rst_n |=> !out_tvalid_r, "result valid right after reset")

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for segment_state_checker_core: commands are streamed
// in under random backpressure, every result is checked against an internal
// model of the segment table, and the registers are reprogrammed between
// phases.
// ----------------------------------------------------------------------------
module tb_top;
  import ssc_pkg::*;

  localparam int MAX_SEG     = 1024;
  localparam int CMD_W       = OP_W + ID_W + 2 * BYTE_W;
  localparam int QUIET_LIMIT = 20000;
  localparam int STALL_LEN   = 400;

  // One command item, opcode in the low bits as on in_tdata.
  typedef struct packed {
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] off;
    logic [ID_W-1:0]   seg_id;
    logic [OP_W-1:0]   op;
  } seg_cmd_t;

  // One result item, status in the low bits as on out_tdata.
  typedef struct packed {
    logic [BYTE_W-1:0] unused;
    logic [RC_W-1:0]   status;
  } seg_result_t;

  logic               clk;
  logic               rst_n       = 1'b0;
  logic               in_tvalid   = 1'b0;
  logic               in_tready;
  logic [IN_W-1:0]    in_tdata    = '0;
  logic               out_tvalid;
  logic               out_tready  = 1'b0;
  logic [OUT_W-1:0]   out_tdata;
  logic               cfg_psel    = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite  = 1'b0;
  logic [APB_AW-1:0]  cfg_paddr   = '0;
  logic [APB_DW-1:0]  cfg_pwdata  = '0;
  logic [APB_DW-1:0]  cfg_prdata;
  logic               cfg_pready;

  // Model copy of the registers and of the segment table.
  logic [LOG_W-1:0]   cfg_blk_log2 = BLK_LOG2_RST;
  logic [BYTE_W-1:0]  cfg_seg_size = SEG_SIZE_RST;
  logic [NSEG_W-1:0]  cfg_num_seg  = NUM_SEG_RST;
  logic [SEG_W-1:0]   seg_state [MAX_SEG];
  logic [BYTE_W-1:0]  seg_wp    [MAX_SEG];

  seg_cmd_t           cmd_backlog [$];
  seg_result_t        pending_results [$];
  seg_result_t        want_res;
  seg_result_t        got_res;
  int                 mismatch_cnt  = 0;
  int                 quiet_cycles  = 0;
  int                 queued_cnt    = 0;
  int                 send_idle_pct = 27;
  int                 recv_idle_pct = 53;
  int                 hold_left     = 0;
  bit                 stall_req     = 1'b0;
  bit                 in_fire       = 1'b0;

  segment_state_checker_core #(
    .MAX_SEGMENTS(MAX_SEG)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // --------------------------------------------------------------------------
  // Segment table model
  // --------------------------------------------------------------------------

  function automatic logic [63:0] active_count();
    return (cfg_num_seg < MAX_SEG) ? 64'(cfg_num_seg) : 64'(MAX_SEG);
  endfunction

  function automatic bit is_aligned(logic [63:0] v);
    return (v & ((64'd1 << cfg_blk_log2) - 64'd1)) == 64'd0;
  endfunction

  // Apply one command to the table copy and return the result it must yield.
  function automatic seg_result_t apply_segment_cmd(seg_cmd_t c);
    seg_result_t r;
    logic [63:0] seg;
    logic [63:0] off;
    logic [63:0] len;
    logic [63:0] span;
    logic [63:0] ptr;
    logic        hit;
    int          ix;
    seg  = 64'(cfg_seg_size);
    off  = 64'(c.off);
    len  = 64'(c.len);
    span = off + len;
    hit  = 64'(c.seg_id) < active_count();
    // An id out of range still indexes entry 0; every path below ignores it.
    ix   = hit ? int'(c.seg_id) : 0;
    ptr  = 64'(seg_wp[ix]);
    r.status = RC_INVAL;
    r.unused = '0;
    case (c.op)
      OP_OPEN: begin
        if (hit && seg_state[ix] == SEG_EMPTY) begin
          seg_state[ix] = SEG_OPEN;
          seg_wp[ix]    = '0;
          r.status      = RC_OK;
        end
      end
      OP_CLOSE: begin
        if (hit) begin
          seg_state[ix] = SEG_CLOSED;
          // Saturate at zero when the pointer ran past a shrunken segment.
          r.unused      = (seg > ptr) ? BYTE_W'(seg - ptr) : '0;
          r.status      = RC_OK;
        end
      end
      OP_RELEASE: begin
        if (hit && seg_state[ix] == SEG_CLOSED) begin
          seg_state[ix] = SEG_EMPTY;
          r.status      = RC_OK;
        end
      end
      OP_WRITE: begin
        if (!hit || seg_state[ix] != SEG_OPEN)
          r.status = RC_INVAL;
        else if (off < ptr || !is_aligned(off) || !is_aligned(len))
          r.status = RC_INVAL;
        else if (span > seg)
          r.status = RC_NOSPC;
        else begin
          seg_wp[ix] = span[BYTE_W-1:0];
          r.status   = RC_OK;
        end
      end
      OP_READ: begin
        if (!is_aligned(off) || !is_aligned(len) || !hit || span > seg)
          r.status = RC_INVAL;
        else if (seg_state[ix] == SEG_EMPTY)
          r.status = RC_NOENT;
        else
          r.status = RC_OK;
      end
      OP_RECOVER: begin
        for (int i = 0; i < int'(active_count()); i++) begin
          if (seg_state[i] == SEG_OPEN) seg_state[i] = SEG_CLOSED;
        end
        r.status = RC_OK;
      end
      default: r.status = RC_INVAL;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    in_fire = rst_n && in_tvalid && in_tready;
    quiet_cycles = quiet_cycles + 1;
    // Check the result first; its expectation was queued cycles earlier.
    if (rst_n && out_tvalid && out_tready) begin
      quiet_cycles = 0;
      got_res = out_tdata[RC_W+BYTE_W-1:0];
      if (pending_results.size() == 0) begin
        mismatch_cnt = mismatch_cnt + 1;
        if (mismatch_cnt <= 10)
          $display("ERROR: result item with nothing expected: status %0d unused %0d",
                   got_res.status, got_res.unused);
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.status !== want_res.status || got_res.unused !== want_res.unused) begin
          mismatch_cnt = mismatch_cnt + 1;
          if (mismatch_cnt <= 10)
            $display("ERROR: status %0d unused %0d, expected status %0d unused %0d",
                     got_res.status, got_res.unused, want_res.status, want_res.unused);
        end
      end
    end
    if (in_fire) begin
      quiet_cycles = 0;
      pending_results.insert(pending_results.size(),
                             apply_segment_cmd(in_tdata[CMD_W-1:0]));
    end
  end

  // --------------------------------------------------------------------------
  // Driver: offer the next command at the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tdata  <= {{(IN_W-CMD_W){1'b0}}, cmd_backlog.pop_front()};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random backpressure, plus one long hold-off on request.
  always @(negedge clk) begin
    if (stall_req) begin
      hold_left = STALL_LEN;
      stall_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic push_cmd(logic [OP_W-1:0] op, logic [63:0] id, logic [63:0] off,
                          logic [63:0] len);
    seg_cmd_t c;
    c.op     = op;
    c.seg_id = id[ID_W-1:0];
    c.off    = off[BYTE_W-1:0];
    c.len    = len[BYTE_W-1:0];
    cmd_backlog.insert(cmd_backlog.size(), c);
    queued_cnt = queued_cnt + 1;
  endtask

  // Hold until every command is taken and answered, then let the block settle.
  task automatic drain();
    while (cmd_backlog.size() > 0 || in_tvalid || pending_results.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [APB_DW-1:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_BLK_LOG2: cfg_blk_log2 = val[LOG_W-1:0];
      REG_SEG_SIZE: cfg_seg_size = val[BYTE_W-1:0];
      REG_NUM_SEG:  cfg_num_seg  = val[NSEG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic reprogram(int blk, logic [63:0] seg, int nseg, int send_pct, int recv_pct);
    drain();
    write_reg(REG_BLK_LOG2, APB_DW'(blk));
    write_reg(REG_SEG_SIZE, seg[APB_DW-1:0]);
    write_reg(REG_NUM_SEG, APB_DW'(nseg));
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Full life of one segment: open, a run of writes with reads between, close
  // and usually release. Mostly legal, with some broken writes mixed in.
  task automatic segment_life();
    logic [63:0] id;
    logic [63:0] blk_sz;
    logic [63:0] seg;
    logic [63:0] ptr;
    logic [63:0] off;
    logic [63:0] len;
    int          pick;
    id     = 64'($urandom_range(0, 7));
    blk_sz = 64'd1 << cfg_blk_log2;
    seg    = 64'(cfg_seg_size);
    ptr    = 0;
    push_cmd(OP_OPEN, id, 0, 0);
    repeat ($urandom_range(1, 6)) begin
      pick = $urandom_range(0, 99);
      off  = ptr;
      len  = blk_sz;
      if (pick < 70) begin
        len = blk_sz * 64'($urandom_range(0, 4));
      end else if (pick < 78) begin
        off = seg & ~(blk_sz - 1);
      end else if (pick < 84) begin
        off = ptr + blk_sz * 64'($urandom_range(1, 3));
      end else if (pick < 90) begin
        off = (ptr >= blk_sz) ? ptr - blk_sz : ptr + 1;
      end else if (pick < 95) begin
        off = ptr + 1;
      end else begin
        len = blk_sz + 1;
      end
      off = off & 64'h7FFF_FFFF;
      len = len & 64'h7FFF_FFFF;
      push_cmd(OP_WRITE, id, off, len);
      // Track the pointer only for a write that lands.
      if (off >= ptr && is_aligned(off) && is_aligned(len) && off + len <= seg)
        ptr = off + len;
      if ($urandom_range(0, 99) < 40) begin
        if ($urandom_range(0, 1) == 1) push_cmd(OP_READ, id, 0, ptr);
        else push_cmd(OP_READ, id, blk_sz * 64'($urandom_range(0, 3)),
                      blk_sz * 64'($urandom_range(0, 3)));
      end
    end
    push_cmd(OP_CLOSE, id, 0, 0);
    if ($urandom_range(0, 99) < 75) push_cmd(OP_RELEASE, id, 0, 0);
  endtask

  // Single command, either fully random or of a chosen kind with an id at the id range edge or random.
  task automatic noise_cmd();
    logic [63:0] blk_sz;
    logic [63:0] edge_id;
    logic [63:0] id;
    int          pick;
    blk_sz  = 64'd1 << cfg_blk_log2;
    edge_id = active_count();
    if ($urandom_range(0, 99) < 30) begin
      push_cmd(OP_W'($urandom_range(0, 7)), 64'($urandom), 64'($urandom),
               64'($urandom));
    end else begin
      case ($urandom_range(0, 2))
        0:       id = (edge_id == 0) ? 0 : edge_id - 1;
        1:       id = edge_id;
        default: id = 64'($urandom);
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 15)      push_cmd(OP_OPEN, id, 0, 0);
      else if (pick < 30) push_cmd(OP_CLOSE, id, 0, 0);
      else if (pick < 45) push_cmd(OP_RELEASE, id, 0, 0);
      else if (pick < 65) push_cmd(OP_WRITE, id, blk_sz * 64'($urandom_range(0, 7)),
                                   blk_sz * 64'($urandom_range(0, 3)));
      else if (pick < 92) push_cmd(OP_READ, id, blk_sz * 64'($urandom_range(0, 7)),
                                   blk_sz * 64'($urandom_range(0, 3)));
      else if (pick < 96) push_cmd(OP_RECOVER, id, 0, 0);
      else                push_cmd(OP_W'($urandom_range(6, 7)), id, 64'($urandom),
                                   64'($urandom));
    end
  endtask

  task automatic random_cmds(int count);
    int goal;
    goal = queued_cnt + count;
    while (queued_cnt < goal) begin
      if ($urandom_range(0, 99) < 60) segment_life();
      else noise_cmd();
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < MAX_SEG; i++) begin
      seg_state[i] = SEG_EMPTY;
      seg_wp[i]    = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part under the reset register values: 4 KiB blocks, 64 MiB
    // segments, all 1024 ids active.
    push_cmd(OP_READ, 5, 0, 0);                    // read of an empty segment
    push_cmd(OP_WRITE, 5, 0, 4096);                // write before open
    push_cmd(OP_RELEASE, 5, 0, 0);                 // release while empty
    push_cmd(OP_OPEN, 5, 0, 0);
    push_cmd(OP_OPEN, 5, 0, 0);                    // open twice
    push_cmd(OP_WRITE, 5, 0, 4096);
    push_cmd(OP_WRITE, 5, 0, 4096);                // offset below the pointer
    push_cmd(OP_WRITE, 5, 4097, 4096);             // unaligned offset
    push_cmd(OP_WRITE, 5, 8192, 100);              // unaligned length
    push_cmd(OP_WRITE, 5, 67104768, 8192);         // runs past the segment end
    push_cmd(OP_WRITE, 5, 67104768, 4096);         // fills the segment exactly
    push_cmd(OP_READ, 5, 0, 67108864);
    push_cmd(OP_READ, 5, 4096, 67108864);          // read past the end
    push_cmd(OP_READ, 5, 1, 0);                    // unaligned read
    push_cmd(OP_CLOSE, 5, 0, 0);                   // nothing left unwritten
    push_cmd(OP_CLOSE, 1023, 0, 0);                // close straight from empty
    push_cmd(OP_RELEASE, 5, 0, 0);
    push_cmd(OP_RELEASE, 1023, 0, 0);
    push_cmd(OP_OPEN, 0, 0, 0);
    push_cmd(OP_WRITE, 0, 0, 8192);
    push_cmd(OP_RECOVER, 0, 0, 0);
    push_cmd(OP_WRITE, 0, 8192, 4096);             // segment closed by recover
    push_cmd(OP_CLOSE, 0, 0, 0);
    push_cmd(3'd6, 1, 0, 0);                       // unused opcodes
    push_cmd(3'd7, 1023, 64'h7FFF_FFFF, 64'h7FFF_FFFF);
    push_cmd(OP_WRITE, 1023, 64'h7FFF_FFFF, 64'h7FFF_FFFF);

    random_cmds(250);
    // Hold the receiver off once while commands keep coming, so the block
    // backs up into its input.
    while (cmd_backlog.size() > queued_cnt - 60) @(posedge clk);
    stall_req = 1'b1;

    // Small blocks, largest segments, count above the table size.
    reprogram(9, 64'h7FFF_FFFF, 2047, 27, 53);
    random_cmds(250);
    // Leave segment 3 open with a 1 MiB pointer for the next phase.
    push_cmd(OP_CLOSE, 3, 0, 0);
    push_cmd(OP_RELEASE, 3, 0, 0);
    push_cmd(OP_OPEN, 3, 0, 0);
    push_cmd(OP_WRITE, 3, 0, 1 << 20);

    // Shrink segments below that pointer: the close must saturate at zero.
    reprogram(16, 1, 8, 53, 27);
    push_cmd(OP_CLOSE, 3, 0, 0);
    random_cmds(200);

    // No active segments at all, alignment trivial.
    reprogram(0, 1000, 0, 53, 27);
    random_cmds(100);

    // Widest block setting, full table.
    reprogram(31, 64'h7FFF_FFFF, 1024, 0, 0);
    random_cmds(100);

    reprogram(13, 1 << 20, 1024, 0, 0);
    random_cmds(200);

    drain();
    repeat (20) @(posedge clk);
    if (pending_results.size() > 0)
      $display("ERROR: %0d result items never arrived", pending_results.size());
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
